// ===== rtl/ellipse_pixel_mask_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ellipse pixel mask
// Each macro takes a label, the clock, the reset, a condition and a check.
// ----------------------------------------------------------------------------
`ifndef ELLIPSE_PIXEL_MASK_TOP_ASSERT_SVH
`define ELLIPSE_PIXEL_MASK_TOP_ASSERT_SVH

// The check must hold in the same cycle as the condition.
`define EPM_ASSERT_IMP(label, clk, rst, cond, check) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
      else $error("ellipse pixel mask: assertion failed");

// The check must hold in the cycle after the condition.
`define EPM_ASSERT_NEXT(label, clk, rst, cond, check) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
      else $error("ellipse pixel mask: assertion failed");

`endif

// ===== rtl/epm_pkg.sv =====
// ----------------------------------------------------------------------------
// Ellipse pixel mask package
// Widths, constants, configuration codes and pipeline payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package epm_pkg;

   localparam int MAX_DIM    = 4096;
   localparam int MIN_DIM    = 2;
   localparam int RESET_DIM  = 64;
   localparam int DIM_W      = 13;
   localparam int COORD_W    = 12;
   localparam int PIX_W      = 32;
   localparam int HALF_W     = DIM_W - 1;
   localparam int SQ_W       = 2 * HALF_W;
   localparam int SCALE      = 10000;
   localparam int SCALE_W    = $clog2(SCALE + 1);
   localparam int PROD_W     = SQ_W + SCALE_W;
   localparam int Q_W        = SCALE_W;
   localparam int SUM_W      = Q_W + 1;
   localparam int DIV_STAGES = Q_W;
   localparam int CSR_IDX_W  = 1;

   localparam logic [PIX_W-1:0] BLACK_OPAQUE = 32'h0000_00FF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_idx_type;

   // Effective frame geometry, derived once per register write.
   typedef struct packed {
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [HALF_W-1:0] half_x;
      logic [HALF_W-1:0] half_y;
      logic [SQ_W-1:0]   sq_x;
      logic [SQ_W-1:0]   sq_y;
   } cfg_type;

   // Scaled squared offsets, ready for division.
   typedef struct packed {
      logic [PROD_W-1:0] prod_x;
      logic [PROD_W-1:0] prod_y;
      logic [PIX_W-1:0]  pixel;
      logic              in_frame;
   } prod_type;

   // Partial remainders and quotients of the two axis divisions.
   typedef struct packed {
      logic [PROD_W-1:0] rem_x;
      logic [PROD_W-1:0] rem_y;
      logic [Q_W-1:0]    quo_x;
      logic [Q_W-1:0]    quo_y;
      logic [PIX_W-1:0]  pixel;
      logic              in_frame;
   } div_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value);
      logic [DIM_W-1:0] result;
      result = value;
      if (32'(value) < MIN_DIM) begin
         result = DIM_W'(MIN_DIM);
      end else if (32'(value) > MAX_DIM) begin
         result = DIM_W'(MAX_DIM);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/epm_req_if.sv =====
// ----------------------------------------------------------------------------
// Ellipse pixel mask request channel
// Valid/ready channel carrying one pixel and its coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface epm_req_if;
   logic                         valid;
   logic                         ready;
   logic [epm_pkg::COORD_W-1:0]  pixel_row;
   logic [epm_pkg::COORD_W-1:0]  pixel_col;
   logic [epm_pkg::PIX_W-1:0]    pixel_in;

   modport source (output valid, output pixel_row, output pixel_col, output pixel_in,
                   input ready);
   modport sink   (input valid, input pixel_row, input pixel_col, input pixel_in,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/epm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Ellipse pixel mask result channel
// Valid/ready channel carrying the masked pixel and the inside flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface epm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [epm_pkg::PIX_W-1:0]  pixel_out;
   logic                       inside_res;

   modport source (output valid, output pixel_out, output inside_res, input ready);
   modport sink   (input valid, input pixel_out, input inside_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/epm_cfg.sv =====
// ----------------------------------------------------------------------------
// Ellipse pixel mask configuration
// Holds the clamped frame size and the squared semi-axes.
// ----------------------------------------------------------------------------
`default_nettype none

module epm_cfg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [epm_pkg::CSR_IDX_W-1:0] csr_idx,
   input  logic [epm_pkg::DIM_W-1:0]     csr_wdata,
   output epm_pkg::cfg_type              cfg
);
   import epm_pkg::*;

   logic [DIM_W-1:0]  width_ff, width_in;
   logic [DIM_W-1:0]  height_ff, height_in;
   logic [HALF_W-1:0] half_x, half_y;
   logic [SQ_W-1:0]   sq_x_ff, sq_x_in;
   logic [SQ_W-1:0]   sq_y_ff, sq_y_in;

   assign half_x = width_ff[DIM_W-1:1];
   assign half_y = height_ff[DIM_W-1:1];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_idx))
            CSR_FRAME_WIDTH:  width_in  = clamp_dim(csr_wdata);
            CSR_FRAME_HEIGHT: height_in = clamp_dim(csr_wdata);
         endcase
      end
   end

   // The squares are registered from the dimensions, so they follow them in the
   // next cycle; no request reaches the divider that soon after a write.
   assign sq_x_in = SQ_W'(half_x) * SQ_W'(half_x);
   assign sq_y_in = SQ_W'(half_y) * SQ_W'(half_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(RESET_DIM);
         height_ff <= DIM_W'(RESET_DIM);
         sq_x_ff   <= SQ_W'((RESET_DIM / 2) * (RESET_DIM / 2));
         sq_y_ff   <= SQ_W'((RESET_DIM / 2) * (RESET_DIM / 2));
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         sq_x_ff   <= sq_x_in;
         sq_y_ff   <= sq_y_in;
      end
   end

   assign cfg = '{width: width_ff, height: height_ff, half_x: half_x, half_y: half_y,
                  sq_x: sq_x_ff, sq_y: sq_y_ff};

endmodule

`default_nettype wire

// ===== rtl/epm_front.sv =====
// ----------------------------------------------------------------------------
// Ellipse pixel mask front end
// Three stages: offsets from the center, squares, and scaling by 10000.
// ----------------------------------------------------------------------------
`default_nettype none

module epm_front (
   input  logic              clock,
   input  logic              reset,
   input  epm_pkg::cfg_type  cfg,
   epm_req_if.sink           req_bus,
   output logic              out_valid,
   input  logic              out_ready,
   output epm_pkg::prod_type out_data
);
   import epm_pkg::*;

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic              s1_ready, s2_ready, s3_ready;
   logic [HALF_W-1:0] col_h, row_h;
   logic [HALF_W-1:0] s1_dx_ff, s1_dx_in, s1_dy_ff, s1_dy_in;
   logic              s1_frame_ff, s1_frame_in;
   logic [PIX_W-1:0]  s1_pixel_ff;
   logic [SQ_W-1:0]   s2_sqx_ff, s2_sqx_in, s2_sqy_ff, s2_sqy_in;
   logic              s2_frame_ff;
   logic [PIX_W-1:0]  s2_pixel_ff;
   prod_type          s3_ff, s3_in;

   assign s3_ready      = !s3_valid_ff || out_ready;
   assign s2_ready      = !s2_valid_ff || s3_ready;
   assign s1_ready      = !s1_valid_ff || s2_ready;
   assign req_bus.ready = s1_ready;

   assign col_h = HALF_W'(req_bus.pixel_col);
   assign row_h = HALF_W'(req_bus.pixel_row);

   always_comb begin
      s1_dx_in    = (col_h >= cfg.half_x) ? col_h - cfg.half_x : cfg.half_x - col_h;
      s1_dy_in    = (row_h >= cfg.half_y) ? row_h - cfg.half_y : cfg.half_y - row_h;
      s1_frame_in = (DIM_W'(req_bus.pixel_col) < cfg.width) &&
                    (DIM_W'(req_bus.pixel_row) < cfg.height);
   end

   assign s2_sqx_in = SQ_W'(s1_dx_ff) * SQ_W'(s1_dx_ff);
   assign s2_sqy_in = SQ_W'(s1_dy_ff) * SQ_W'(s1_dy_ff);

   always_comb begin
      s3_in.prod_x   = PROD_W'(s2_sqx_ff) * PROD_W'(SCALE);
      s3_in.prod_y   = PROD_W'(s2_sqy_ff) * PROD_W'(SCALE);
      s3_in.pixel    = s2_pixel_ff;
      s3_in.in_frame = s2_frame_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_dx_ff    <= s1_dx_in;
         s1_dy_ff    <= s1_dy_in;
         s1_frame_ff <= s1_frame_in;
         s1_pixel_ff <= req_bus.pixel_in;
      end
      if (s2_ready) begin
         s2_sqx_ff   <= s2_sqx_in;
         s2_sqy_ff   <= s2_sqy_in;
         s2_frame_ff <= s1_frame_ff;
         s2_pixel_ff <= s1_pixel_ff;
      end
      if (s3_ready) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_ff;

endmodule

`default_nettype wire

// ===== rtl/epm_div.sv =====
// ----------------------------------------------------------------------------
// Ellipse pixel mask divider
// Pipelined restoring division, one quotient bit per stage on both axes.
// ----------------------------------------------------------------------------
`default_nettype none

module epm_div (
   input  logic              clock,
   input  logic              reset,
   input  epm_pkg::cfg_type  cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  epm_pkg::prod_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output epm_pkg::div_type  out_data
);
   import epm_pkg::*;

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES-1:0] src_valid;
   logic [DIV_STAGES-1:0] ready;
   div_type               data_ff [DIV_STAGES];
   div_type               data_in [DIV_STAGES];
   div_type               src     [DIV_STAGES];

   // A stage may load when it or any stage after it is empty, or the
   // consumer takes the last one.
   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         ready[s] = out_ready ||
                    ((valid_ff >> s) != ({DIV_STAGES{1'b1}} >> s));
      end
   end

   always_comb begin
      src_valid[0] = in_valid;
      src[0]       = '{rem_x: in_data.prod_x, rem_y: in_data.prod_y,
                       quo_x: '0, quo_y: '0,
                       pixel: in_data.pixel, in_frame: in_data.in_frame};
      for (int s = 1; s < DIV_STAGES; s++) begin
         src_valid[s] = valid_ff[s-1];
         src[s]       = data_ff[s-1];
      end
   end

   // Stage s settles quotient bit DIV_STAGES-1-s against the divisor
   // shifted into that position.
   always_comb begin : div_step
      logic [PROD_W-1:0] dvs_x;
      logic [PROD_W-1:0] dvs_y;
      for (int s = 0; s < DIV_STAGES; s++) begin
         dvs_x      = PROD_W'(cfg.sq_x) << (DIV_STAGES - 1 - s);
         dvs_y      = PROD_W'(cfg.sq_y) << (DIV_STAGES - 1 - s);
         data_in[s] = src[s];
         if (src[s].rem_x >= dvs_x) begin
            data_in[s].rem_x                    = src[s].rem_x - dvs_x;
            data_in[s].quo_x[DIV_STAGES - 1 - s] = 1'b1;
         end
         if (src[s].rem_y >= dvs_y) begin
            data_in[s].rem_y                    = src[s].rem_y - dvs_y;
            data_in[s].quo_y[DIV_STAGES - 1 - s] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            if (ready[s]) begin
               valid_ff[s] <= src_valid[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (ready[s]) begin
            data_ff[s] <= data_in[s];
         end
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_data  = data_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/ellipse_pixel_mask_top.sv =====
// ----------------------------------------------------------------------------
// Ellipse pixel mask
// Streams RGBA pixels and blacks out those outside the inscribed ellipse.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req_bus (valid/ready) with a pixel, its row and column.
// Results leave on rsp_bus (valid/ready) in request order, one per request:
// the pixel unchanged with inside_res set, or opaque black 0x000000FF.
// The frame width and height are written through csr_we/csr_idx/csr_wdata
// while no request is in flight; values below 2 or above the maximum frame
// size are clamped.
// From acceptance to rsp_bus.valid a request passes one stage for the center
// offsets, one for the squares, one for the scaling by 10000, 14 divider
// stages (one quotient bit each) and the output register.
// Throughput is one request per cycle; a new request is taken every cycle
// the pipeline has room.
// When the receiver stalls, the result holds in the output register and the
// stages behind it keep filling until all are occupied, then req_bus.ready
// drops. Nothing is lost or repeated.
// Reset (synchronous) empties the pipeline and sets both dimensions to 64.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ellipse_pixel_mask_top_assert.svh"

module ellipse_pixel_mask_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [epm_pkg::CSR_IDX_W-1:0] csr_idx,
   input  logic [epm_pkg::DIM_W-1:0]     csr_wdata,
   epm_req_if.sink                       req_bus,
   epm_rsp_if.source                     rsp_bus
);
   import epm_pkg::*;

   cfg_type          cfg;
   logic             front_valid, front_ready;
   prod_type         front_data;
   logic             div_valid, div_ready;
   div_type          div_data;
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic             rsp_inside_ff, rsp_inside_in;
   logic [SUM_W-1:0] term_sum;

   epm_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   epm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_bus   (req_bus),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   epm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   assign div_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      term_sum      = SUM_W'(div_data.quo_x) + SUM_W'(div_data.quo_y);
      rsp_inside_in = div_data.in_frame && (term_sum <= SUM_W'(SCALE));
      rsp_pixel_in  = rsp_inside_in ? div_data.pixel : BLACK_OPAQUE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_ready) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready) begin
         rsp_pixel_ff  <= rsp_pixel_in;
         rsp_inside_ff <= rsp_inside_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.pixel_out  = rsp_pixel_ff;
   assign rsp_bus.inside_res = rsp_inside_ff;

   `EPM_ASSERT_IMP(a_black_when_outside, clock, reset, rsp_bus.valid && !rsp_bus.inside_res, rsp_bus.pixel_out == BLACK_OPAQUE)
   `EPM_ASSERT_IMP(a_dims_clamped, clock, reset, 1'b1, cfg.width >= DIM_W'(MIN_DIM) && cfg.height >= DIM_W'(MIN_DIM))
   `EPM_ASSERT_NEXT(a_square_tracks_half, clock, reset, 1'b1, cfg.sq_x == SQ_W'($past(cfg.half_x)) * SQ_W'($past(cfg.half_x)))

endmodule

`default_nettype wire
